// ===== rtl/mnr_pkg.sv =====
// mnr_pkg: shared types for the mixed number reducer
// holds the controller state encoding and the divider status bundle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mnr_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WHOLE_GO,
        S_WHOLE_WAIT,
        S_MUL,
        S_ADD,
        S_GCD,
        S_GCD_WAIT,
        S_NUM_GO,
        S_NUM_WAIT,
        S_DEN_GO,
        S_DEN_WAIT,
        S_OUT
    } mnr_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mnr_div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mnr_divider.sv =====
// mnr_divider: iterative signed divider, one quotient bit per cycle
// truncating quotient and remainder, remainder takes the dividend sign
// depends on mnr_pkg for the status bundle
`timescale 1ns / 1ps
`default_nettype none

module mnr_divider
    import mnr_pkg::*;
#(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] dividend,
    input  wire logic signed [DEN_W-1:0] divisor,
    output mnr_div_stat_t                stat,
    output logic signed [NUM_W-1:0]      quotient,
    output logic signed [DEN_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] dvd_reg, dvd_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] dvs_reg, dvs_next;
    logic             neg_q_reg, neg_q_next;
    logic             neg_r_reg, neg_r_next;

    logic [NUM_W-1:0] mag_dvd;
    logic [DEN_W-1:0] mag_dvs;
    logic             narrow;
    logic [DEN_W-1:0] trial;
    logic [DEN_W-1:0] diff;
    logic             fits;

    always_comb
    begin
        mag_dvd = dividend[NUM_W-1] ? NUM_W'(~dividend + 1'b1) : NUM_W'(dividend);
        mag_dvs = divisor[DEN_W-1] ? DEN_W'(~divisor + 1'b1) : DEN_W'(divisor);
        // small dividends skip the leading zero bits
        narrow  = (mag_dvd[NUM_W-1:DEN_W] == '0);
        trial   = {rem_reg[DEN_W-2:0], dvd_reg[NUM_W-1]};
        diff    = trial - dvs_reg;
        fits    = (trial >= dvs_reg);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = narrow ? CNT_W'(DEN_W) : CNT_W'(NUM_W);
            dvd_next   = narrow ? (mag_dvd << (NUM_W - DEN_W)) : mag_dvd;
            rem_next   = '0;
            dvs_next   = mag_dvs;
            neg_q_next = dividend[NUM_W-1] ^ divisor[DEN_W-1];
            neg_r_next = dividend[NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff : trial;
            dvd_next = {dvd_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_q_reg ? NUM_W'(~dvd_reg + 1'b1) : dvd_reg;
    assign remainder = neg_r_reg ? DEN_W'(~rem_reg + 1'b1) : rem_reg;

endmodule

`default_nettype wire

// ===== rtl/mixed_number_reducer.sv =====
// mixed_number_reducer: top level, controller and datapath around one divider
// depends on mnr_pkg and mnr_divider
//
// channel   signals                                     direction
// -------   -----------------------------------------   ---------
// input     in_valid in_ready whole_in numer_in denom_in    in
// result    out_valid out_ready whole_out numer_out         out
//           denom_out div_error
// config    cfg_wr_en cfg_wr_data (to_fraction_mode)        in
//
// every division goes through the shared bit-serial divider, which skips the leading
// zero bits of a dividend whose magnitude fits in DATA_WIDTH+1 bits; one item at a time
// a zero denominator goes straight to the result; in_ready is high only while idle
// the result register holds until its transfer; reset clears the controller, sets mixed mode
`timescale 1ns / 1ps
`default_nettype none

module mixed_number_reducer
    import mnr_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] whole_in,
    input  wire logic signed [DATA_WIDTH-1:0] numer_in,
    input  wire logic signed [DATA_WIDTH-1:0] denom_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [16:0]                whole_out,
    output logic signed [31:0]                numer_out,
    output logic signed [16:0]                denom_out,
    output logic                              div_error
);

    localparam int NUM_W = 2 * DATA_WIDTH + 1;
    localparam int DEN_W = DATA_WIDTH + 1;
    localparam int PRD_W = 2 * DATA_WIDTH;

    mnr_state_t state_reg, state_next;
    logic       mode_reg;

    logic signed [DATA_WIDTH-1:0] w_reg, w_next;
    logic signed [DATA_WIDTH-1:0] n_reg, n_next;
    logic signed [DATA_WIDTH-1:0] d_reg, d_next;
    logic signed [PRD_W-1:0]      prod_reg, prod_next;
    logic signed [NUM_W-1:0]      a_reg, a_next;
    logic signed [DEN_W-1:0]      b_reg, b_next;
    logic signed [NUM_W-1:0]      num_reg, num_next;
    logic signed [DEN_W-1:0]      whole_reg, whole_next;
    logic signed [NUM_W-1:0]      numq_reg, numq_next;
    logic signed [DEN_W-1:0]      denq_reg, denq_next;
    logic                         err_reg, err_next;

    logic                    div_start;
    logic signed [NUM_W-1:0] div_dividend;
    logic signed [DEN_W-1:0] div_divisor;
    mnr_div_stat_t           div_stat;
    logic signed [NUM_W-1:0] div_quot;
    logic signed [DEN_W-1:0] div_rem;

    logic signed [NUM_W-1:0] n_wide;
    logic signed [NUM_W-1:0] d_wide;
    logic signed [NUM_W-1:0] b_wide;
    logic signed [DEN_W-1:0] d_ext;
    logic signed [DEN_W-1:0] w_ext;

    logic [NUM_W+31:0] numer_ext;
    logic [DEN_W+16:0] whole_ext;
    logic [DEN_W+16:0] denom_ext;

    mnr_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign n_wide = {{(NUM_W-DATA_WIDTH){n_reg[DATA_WIDTH-1]}}, n_reg};
    assign d_wide = {{(NUM_W-DATA_WIDTH){d_reg[DATA_WIDTH-1]}}, d_reg};
    assign b_wide = {{(NUM_W-DEN_W){b_reg[DEN_W-1]}}, b_reg};
    assign d_ext  = {d_reg[DATA_WIDTH-1], d_reg};
    assign w_ext  = {w_reg[DATA_WIDTH-1], w_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (denom_in == '0)
                        state_next = S_OUT;
                    else if (mode_reg)
                        state_next = S_MUL;
                    else
                        state_next = S_WHOLE_GO;
                end
            end
            S_WHOLE_GO:   state_next = S_WHOLE_WAIT;
            S_WHOLE_WAIT: if (div_stat.done) state_next = S_GCD;
            S_MUL:        state_next = S_ADD;
            S_ADD:        state_next = S_GCD;
            S_GCD:        state_next = (b_reg == '0) ? S_NUM_GO : S_GCD_WAIT;
            S_GCD_WAIT:   if (div_stat.done) state_next = S_GCD;
            S_NUM_GO:     state_next = S_NUM_WAIT;
            S_NUM_WAIT:   if (div_stat.done) state_next = S_DEN_GO;
            S_DEN_GO:     state_next = S_DEN_WAIT;
            S_DEN_WAIT:   if (div_stat.done) state_next = S_OUT;
            S_OUT:        if (out_ready) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        div_start    = 1'b0;
        div_dividend = a_reg;
        div_divisor  = b_reg;
        w_next       = w_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        prod_next    = prod_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        num_next     = num_reg;
        whole_next   = whole_reg;
        numq_next    = numq_reg;
        denq_next    = denq_reg;
        err_next     = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    w_next     = whole_in;
                    n_next     = numer_in;
                    d_next     = denom_in;
                    err_next   = (denom_in == '0);
                    whole_next = '0;
                    numq_next  = '0;
                    denq_next  = '0;
                end
            end
            S_WHOLE_GO:
            begin
                div_start    = 1'b1;
                div_dividend = n_wide;
                div_divisor  = d_ext;
            end
            S_WHOLE_WAIT:
            begin
                if (div_stat.done)
                begin
                    whole_next = w_ext + div_quot[DEN_W-1:0];
                    a_next     = {{(NUM_W-DEN_W){div_rem[DEN_W-1]}}, div_rem};
                    num_next   = {{(NUM_W-DEN_W){div_rem[DEN_W-1]}}, div_rem};
                    b_next     = d_ext;
                end
            end
            S_MUL:
            begin
                prod_next = PRD_W'(w_reg) * PRD_W'(d_reg);
            end
            S_ADD:
            begin
                a_next   = {prod_reg[PRD_W-1], prod_reg} + n_wide;
                num_next = {prod_reg[PRD_W-1], prod_reg} + n_wide;
                b_next   = d_ext;
            end
            S_GCD:
            begin
                // b at zero leaves the signed gcd in a, kept in b from here on
                if (b_reg == '0)
                    b_next = a_reg[DEN_W-1:0];
                else
                    div_start = 1'b1;
            end
            S_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    a_next = b_wide;
                    b_next = div_rem;
                end
            end
            S_NUM_GO:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
            end
            S_NUM_WAIT:
            begin
                if (div_stat.done)
                    numq_next = div_quot;
            end
            S_DEN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = d_wide;
            end
            S_DEN_WAIT:
            begin
                if (div_stat.done)
                    denq_next = div_quot[DEN_W-1:0];
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        prod_reg  <= prod_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        num_reg   <= num_next;
        whole_reg <= whole_next;
        numq_reg  <= numq_next;
        denq_reg  <= denq_next;
        err_reg   <= err_next;
    end

    // wrap or sign extend to the fixed result widths
    assign numer_ext = {{32{numq_reg[NUM_W-1]}}, numq_reg};
    assign whole_ext = {{17{whole_reg[DEN_W-1]}}, whole_reg};
    assign denom_ext = {{17{denq_reg[DEN_W-1]}}, denq_reg};

    assign numer_out = numer_ext[31:0];
    assign whole_out = whole_ext[16:0];
    assign denom_out = denom_ext[16:0];
    assign div_error = err_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and result sides active together");

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_error) |-> (whole_out == '0 && numer_out == '0 && denom_out == '0))
        else $error("error result with nonzero fields");

    a_denom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !div_error) |-> (denq_reg != '0))
        else $error("reduced denominator is zero");
`endif

endmodule

`default_nettype wire

// ===== verif/mixed_number_reducer_checker.sv =====
// mixed_number_reducer_checker: watches the input, result and config ports of the reducer
// predicts each reduced result and compares it with what comes out; no package needed
`timescale 1ns / 1ps

module mixed_number_reducer_checker #(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] whole_in,
    input  logic signed [DATA_WIDTH-1:0] numer_in,
    input  logic signed [DATA_WIDTH-1:0] denom_in,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [16:0]           whole_out,
    input  logic signed [31:0]           numer_out,
    input  logic signed [16:0]           denom_out,
    input  logic                         div_error,
    output int                           mismatch_count,
    output int                           results_owed
);

    typedef struct {
        logic signed [16:0] whole;
        logic signed [31:0] numer;
        logic signed [16:0] denom;
        logic               err;
    } reduced_t;

    reduced_t owed_q[$];
    logic     frac_mode;
    int       errs;

    function automatic reduced_t reduce_number(input longint w, input longint n,
                                               input longint d, input logic frac);
        reduced_t r;
        longint   num;
        longint   den;
        longint   whl;
        longint   a;
        longint   b;
        longint   t;
        r.whole = '0;
        r.numer = '0;
        r.denom = '0;
        r.err   = 1'b0;
        if (d == 0)
        begin
            r.err = 1'b1;
            return r;
        end
        if (frac)
        begin
            num = w * d + n;
            whl = 0;
        end
        else
        begin
            whl = w + n / d;
            num = n % d;
        end
        den = d;
        // euclid on truncating remainders, the sign of the divisor is kept as it falls out
        a = num;
        b = den;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        num = num / a;
        den = den / a;
        r.whole = whl[16:0];
        r.numer = num[31:0];
        r.denom = den[16:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reduced_t want;
        if (!rst_n)
        begin
            owed_q.delete();
            errs = 0;
            frac_mode      <= 1'b0;
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                owed_q.push_back(reduce_number(whole_in, numer_in, denom_in, frac_mode));
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("result transfer with no result owed");
                    errs++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (whole_out !== want.whole)
                    begin
                        $error("whole_out: expected %0d, got %0d", want.whole, whole_out);
                        errs++;
                    end
                    if (numer_out !== want.numer)
                    begin
                        $error("numer_out: expected %0d, got %0d", want.numer, numer_out);
                        errs++;
                    end
                    if (denom_out !== want.denom)
                    begin
                        $error("denom_out: expected %0d, got %0d", want.denom, denom_out);
                        errs++;
                    end
                    if (div_error !== want.err)
                    begin
                        $error("div_error: expected %0d, got %0d", want.err, div_error);
                        errs++;
                    end
                end
            end
            if (cfg_wr_en)
                frac_mode <= cfg_wr_data;
            mismatch_count <= errs;
            results_owed   <= owed_q.size();
        end
    end

endmodule

// ===== verif/tb_mixed_number_reducer.sv =====
// tb_mixed_number_reducer: drives mixed numbers into the reducer in both modes
// with random gaps and result stalls; depends on mixed_number_reducer and the checker
`timescale 1ns / 1ps

module tb_mixed_number_reducer;

    localparam int DW          = 16;
    localparam int STALL_LIMIT = 8000;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 192;
    localparam int PROBES      = 13;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [DW-1:0] whole_in;
    logic signed [DW-1:0] numer_in;
    logic signed [DW-1:0] denom_in;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [16:0]   whole_out;
    logic signed [31:0]   numer_out;
    logic signed [16:0]   denom_out;
    logic                 div_error;
    int                   mismatch_count;
    int                   results_owed;
    int                   idle_cycles;
    bit                   quiet;
    bit                   hold_req;

    // directed cases: zero denominator, zero remainder, zero improper numerator,
    // negative divisor, field extremes
    logic signed [DW-1:0] probe_w [PROBES] =
        '{3, 0, 2, 32767, -32768, -32768, 0, 1, -7, 32767, -1, 0, 5};
    logic signed [DW-1:0] probe_n [PROBES] =
        '{4, 0, 10, 32767, -32768, 32767, -6, -5, 22, -32768, 1, 0, -32768};
    logic signed [DW-1:0] probe_d [PROBES] =
        '{0, 5, 5, 1, -32768, -1, 4, 5, 6, 32767, -32768, 0, 32767};
    bit                   phase_modes [PHASES] = '{1, 0, 1, 0, 1, 0};

    mixed_number_reducer #(.DATA_WIDTH(DW)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .whole_in    (whole_in),
        .numer_in    (numer_in),
        .denom_in    (denom_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .whole_out   (whole_out),
        .numer_out   (numer_out),
        .denom_out   (denom_out),
        .div_error   (div_error)
    );

    mixed_number_reducer_checker #(.DATA_WIDTH(DW)) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .whole_in       (whole_in),
        .numer_in       (numer_in),
        .denom_in       (denom_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .whole_out      (whole_out),
        .numer_out      (numer_out),
        .denom_out      (denom_out),
        .div_error      (div_error),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [DW-1:0] draw_operand();
        int style;
        int v;
        style = $urandom_range(0, 9);
        case (style)
            0, 1, 2: v = $urandom;
            3, 4, 5: v = int'($urandom_range(0, 40)) - 20;
            6:
            begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -1;
                    3: v = 0;
                    default: v = 1;
                endcase
            end
            default: v = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return v[DW-1:0];
    endfunction

    task automatic send_item(input logic [DW-1:0] w, input logic [DW-1:0] n,
                             input logic [DW-1:0] d);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        whole_in <= w;
        numer_in <= n;
        denom_in <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random();
        logic [DW-1:0] d;
        logic [DW-1:0] n;
        int            k;
        d = draw_operand();
        if ($urandom_range(0, 3) == 0)
        begin
            // numerator sharing a factor with the denominator
            k = int'($urandom_range(0, 6)) - 3;
            n = d * k[DW-1:0];
        end
        else
            n = draw_operand();
        send_item(draw_operand(), n, d);
    endtask

    // called right after a transfer or after reset, so lowering valid here is the only drive this step
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
    endtask

    task automatic set_mode(input bit m);
        drain();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side: random stall per result, one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("mixed_number_reducer: mismatch");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid    = 1'b0;
        whole_in    = '0;
        numer_in    = '0;
        denom_in    = '0;
        idle_cycles = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int m = 0; m < 2; m++)
        begin
            set_mode(m[0]);
            for (int i = 0; i < PROBES; i++)
                send_item(probe_w[i], probe_n[i], probe_d[i]);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            set_mode(phase_modes[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                quiet = (p == 2 && i >= 30 && i < 80);
                if (p == 1 && i == 60)
                    hold_req = 1'b1;
                if (p == 3 && i == 40)
                    drain();
                send_random();
            end
        end
        quiet = 1'b0;

        drain();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("mixed_number_reducer: match");
        else
            $display("mixed_number_reducer: mismatch");
        $finish;
    end

endmodule
